// File: hw/rtl/cdnu_pkg.sv
`timescale 1ns / 1ps

package cdnu_pkg;

  localparam int VAL_W     = 48;
  localparam int ITER_W    = 9;
  localparam int WEIGHT_W  = 17;
  localparam int COST_W    = 32;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 64;
  localparam int TERM_W    = 68;
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int LO_W      = 24;
  localparam int WFRAC_W   = 16;
  localparam int QSHIFT    = 15;
  localparam int QUO_W     = VAL_W + QSHIFT;
  localparam int REM_W     = COST_W + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int DIVC_W    = $clog2(DIV_STEPS);

  localparam int FRAC_BITS         = 16;
  localparam int DEF_MAX_NEIGHBORS = 8;
  localparam int BOOST_ROUND       = 50;
  localparam int BOOST_LEVEL       = 10;
  localparam int BOOST_GAIN        = 80;
  localparam int ITER_RESET        = 300;

  localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(1 << WFRAC_W);
  localparam logic signed [VAL_W-1:0] BOOST_THRESH =
    VAL_W'(64'(BOOST_LEVEL) << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] VAL_MAX64 = ACC_W'((64'd1 << (VAL_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] VAL_MIN64 = -VAL_MAX64 - ACC_W'(1);

  // Term order of the weighted products in an update.
  localparam logic [1:0] TERM_OWN_PRICE    = 2'd0;
  localparam logic [1:0] TERM_NBR_PRICE    = 2'd1;
  localparam logic [1:0] TERM_OWN_MISMATCH = 2'd2;
  localparam logic [1:0] TERM_NBR_MISMATCH = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_WEIGHT    = 3'd0,
    CFG_NEIGHBOR_WEIGHT = 3'd1,
    CFG_UNIT_COST       = 3'd2,
    CFG_SCHED_POWER     = 3'd3,
    CFG_POWER_MAX       = 3'd4,
    CFG_POWER_MIN       = 3'd5,
    CFG_NEIGHBOR_COUNT  = 3'd6,
    CFG_MAX_ITER        = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0]     local_weight;
    logic [WEIGHT_W-1:0]     neighbor_weight;
    logic [COST_W-1:0]       unit_cost;
    logic signed [VAL_W-1:0] scheduled_power;
    logic signed [VAL_W-1:0] power_max;
    logic signed [VAL_W-1:0] power_min;
    logic [CNT_W-1:0]        neighbor_count;
    logic [ITER_W-1:0]       max_iterations;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_START,
    OP_ACC,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ADD_TERM,
    OP_ADD_GAIN,
    OP_SAT_PRICE,
    OP_DIV_STEP,
    OP_POWER,
    OP_MISMATCH,
    OP_FINAL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic round_ge_max;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_GAIN,
    ST_SAT,
    ST_DIV,
    ST_POWER,
    ST_MISM,
    ST_FINAL,
    ST_EMIT
  } ctrl_state_t;

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > VAL_MAX64) begin
      r = VAL_W'(VAL_MAX64);
    end else if (v < VAL_MIN64) begin
      r = VAL_W'(VAL_MIN64);
    end else begin
      r = VAL_W'(v);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/cdnu_if.sv
`timescale 1ns / 1ps

interface cdnu_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic signed [cdnu_pkg::VAL_W-1:0] demand;
  logic signed [cdnu_pkg::VAL_W-1:0] renewable;
  logic signed [cdnu_pkg::VAL_W-1:0] neighbor_price;
  logic signed [cdnu_pkg::VAL_W-1:0] neighbor_mismatch_est;

  modport source(output valid, mode, demand, renewable, neighbor_price,
                 neighbor_mismatch_est, input ready);
  modport sink(input valid, mode, demand, renewable, neighbor_price,
               neighbor_mismatch_est, output ready);
endinterface

interface cdnu_out_if;
  logic                              valid;
  logic                              ready;
  logic [cdnu_pkg::ITER_W-1:0]       iteration;
  logic signed [cdnu_pkg::VAL_W-1:0] price;
  logic signed [cdnu_pkg::VAL_W-1:0] mismatch_est;
  logic signed [cdnu_pkg::VAL_W-1:0] power;
  logic                              done_res;

  modport source(output valid, iteration, price, mismatch_est, power, done_res,
                 input ready);
  modport sink(input valid, iteration, price, mismatch_est, power, done_res,
               output ready);
endinterface

// File: hw/rtl/cdnu_cfg_regs.sv
`timescale 1ns / 1ps

module cdnu_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cdnu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdnu_pkg::VAL_W-1:0]      cfg_data,
  output cdnu_pkg::cfg_t                  cfg
);

  cdnu_pkg::cfg_t raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r.local_weight    <= cdnu_pkg::W_ONE;
      raw_r.neighbor_weight <= '0;
      raw_r.unit_cost       <= cdnu_pkg::COST_W'(cdnu_pkg::W_ONE);
      raw_r.scheduled_power <= '0;
      raw_r.power_max       <= '0;
      raw_r.power_min       <= '0;
      raw_r.neighbor_count  <= cdnu_pkg::CNT_W'(1);
      raw_r.max_iterations  <= cdnu_pkg::ITER_W'(cdnu_pkg::ITER_RESET);
    end else if (cfg_we) begin
      unique case (cdnu_pkg::cfg_idx_t'(cfg_index))
        cdnu_pkg::CFG_LOCAL_WEIGHT:
          raw_r.local_weight <= cfg_data[cdnu_pkg::WEIGHT_W-1:0];
        cdnu_pkg::CFG_NEIGHBOR_WEIGHT:
          raw_r.neighbor_weight <= cfg_data[cdnu_pkg::WEIGHT_W-1:0];
        cdnu_pkg::CFG_UNIT_COST:
          raw_r.unit_cost <= cfg_data[cdnu_pkg::COST_W-1:0];
        cdnu_pkg::CFG_SCHED_POWER:    raw_r.scheduled_power <= cfg_data;
        cdnu_pkg::CFG_POWER_MAX:      raw_r.power_max <= cfg_data;
        cdnu_pkg::CFG_POWER_MIN:      raw_r.power_min <= cfg_data;
        cdnu_pkg::CFG_NEIGHBOR_COUNT:
          raw_r.neighbor_count <= cfg_data[cdnu_pkg::CNT_W-1:0];
        cdnu_pkg::CFG_MAX_ITER:
          raw_r.max_iterations <= cfg_data[cdnu_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Weights above one saturate to one and a zero cost acts as the smallest cost.
  always_comb begin
    cfg = raw_r;
    if (raw_r.local_weight > cdnu_pkg::W_ONE) begin
      cfg.local_weight = cdnu_pkg::W_ONE;
    end
    if (raw_r.neighbor_weight > cdnu_pkg::W_ONE) begin
      cfg.neighbor_weight = cdnu_pkg::W_ONE;
    end
    if (raw_r.unit_cost == '0) begin
      cfg.unit_cost = cdnu_pkg::COST_W'(1);
    end
  end

endmodule

// File: hw/rtl/cdnu_ctrl.sv
`timescale 1ns / 1ps

module cdnu_ctrl #(
  parameter int MAX_NEIGHBORS = cdnu_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_mode,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  logic [cdnu_pkg::CNT_W-1:0]  neighbor_count,
  input  cdnu_pkg::dp_status_t        status,
  output cdnu_pkg::dp_cmd_t           cmd
);

  localparam int NB_W = $clog2(MAX_NEIGHBORS + 1);

  cdnu_pkg::ctrl_state_t state_r, state_nxt;
  logic [NB_W-1:0]               seen_r, seen_nxt;
  logic                          active_r, active_nxt;
  logic [1:0]                    term_r, term_nxt;
  logic [cdnu_pkg::DIVC_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [NB_W-1:0] needed;
  logic            accept;
  logic            start_acc;
  logic            nbr_acc;
  logic            round_full;
  logic            emit_go;

  always_comb begin
    if (neighbor_count == '0) begin
      needed = NB_W'(1);
    end else if (int'(neighbor_count) > MAX_NEIGHBORS) begin
      needed = NB_W'(MAX_NEIGHBORS);
    end else begin
      needed = NB_W'(neighbor_count);
    end
  end

  assign in_ready   = (state_r == cdnu_pkg::ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign start_acc  = accept && !in_mode;
  assign nbr_acc    = accept && in_mode && active_r && !status.round_ge_max;
  assign round_full = (seen_r + NB_W'(1)) >= needed;
  assign emit_go    = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdnu_pkg::ST_IDLE: begin
        if (start_acc) begin
          state_nxt = cdnu_pkg::ST_EMIT;
        end else if (nbr_acc && round_full) begin
          state_nxt = cdnu_pkg::ST_MUL_LO;
        end
      end
      cdnu_pkg::ST_MUL_LO: state_nxt = cdnu_pkg::ST_MUL_HI;
      cdnu_pkg::ST_MUL_HI: state_nxt = cdnu_pkg::ST_ADD;
      cdnu_pkg::ST_ADD: begin
        if (term_r == cdnu_pkg::TERM_NBR_PRICE) begin
          state_nxt = cdnu_pkg::ST_GAIN;
        end else if (term_r == cdnu_pkg::TERM_NBR_MISMATCH) begin
          state_nxt = cdnu_pkg::ST_FINAL;
        end else begin
          state_nxt = cdnu_pkg::ST_MUL_LO;
        end
      end
      cdnu_pkg::ST_GAIN: state_nxt = cdnu_pkg::ST_SAT;
      cdnu_pkg::ST_SAT:  state_nxt = cdnu_pkg::ST_DIV;
      cdnu_pkg::ST_DIV: begin
        if (div_cnt_r == cdnu_pkg::DIVC_W'(cdnu_pkg::DIV_STEPS - 1)) begin
          state_nxt = cdnu_pkg::ST_POWER;
        end
      end
      cdnu_pkg::ST_POWER: state_nxt = cdnu_pkg::ST_MISM;
      cdnu_pkg::ST_MISM:  state_nxt = cdnu_pkg::ST_MUL_LO;
      cdnu_pkg::ST_FINAL: state_nxt = cdnu_pkg::ST_EMIT;
      cdnu_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = cdnu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cdnu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = cdnu_pkg::OP_NOP;
    cmd.term = term_r;
    unique case (state_r)
      cdnu_pkg::ST_IDLE: begin
        if (start_acc) begin
          cmd.op = cdnu_pkg::OP_START;
        end else if (nbr_acc) begin
          cmd.op = cdnu_pkg::OP_ACC;
        end
      end
      cdnu_pkg::ST_MUL_LO: cmd.op = cdnu_pkg::OP_MUL_LO;
      cdnu_pkg::ST_MUL_HI: cmd.op = cdnu_pkg::OP_MUL_HI;
      cdnu_pkg::ST_ADD:    cmd.op = cdnu_pkg::OP_ADD_TERM;
      cdnu_pkg::ST_GAIN:   cmd.op = cdnu_pkg::OP_ADD_GAIN;
      cdnu_pkg::ST_SAT:    cmd.op = cdnu_pkg::OP_SAT_PRICE;
      cdnu_pkg::ST_DIV:    cmd.op = cdnu_pkg::OP_DIV_STEP;
      cdnu_pkg::ST_POWER:  cmd.op = cdnu_pkg::OP_POWER;
      cdnu_pkg::ST_MISM:   cmd.op = cdnu_pkg::OP_MISMATCH;
      cdnu_pkg::ST_FINAL:  cmd.op = cdnu_pkg::OP_FINAL;
      cdnu_pkg::ST_EMIT: begin
        if (emit_go) begin
          cmd.op = cdnu_pkg::OP_EMIT;
        end
      end
      default: cmd.op = cdnu_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    seen_nxt      = seen_r;
    active_nxt    = active_r;
    term_nxt      = term_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (start_acc) begin
      seen_nxt   = '0;
      active_nxt = 1'b1;
    end else if (nbr_acc) begin
      seen_nxt = seen_r + NB_W'(1);
    end
    if (state_r == cdnu_pkg::ST_IDLE) begin
      term_nxt = cdnu_pkg::TERM_OWN_PRICE;
    end else if (state_r == cdnu_pkg::ST_ADD) begin
      term_nxt = term_r + 2'd1;
    end else if (state_r == cdnu_pkg::ST_MISM) begin
      term_nxt = cdnu_pkg::TERM_OWN_MISMATCH;
    end
    if (state_r == cdnu_pkg::ST_SAT) begin
      div_cnt_nxt = '0;
    end else if (state_r == cdnu_pkg::ST_DIV) begin
      div_cnt_nxt = div_cnt_r + cdnu_pkg::DIVC_W'(1);
    end
    if (state_r == cdnu_pkg::ST_FINAL) begin
      seen_nxt = '0;
    end
    if (state_r == cdnu_pkg::ST_EMIT && emit_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdnu_pkg::ST_IDLE;
      seen_r      <= '0;
      active_r    <= 1'b0;
      term_r      <= cdnu_pkg::TERM_OWN_PRICE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      active_r    <= active_nxt;
      term_r      <= term_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/cdnu_datapath.sv
`timescale 1ns / 1ps

module cdnu_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cdnu_pkg::dp_cmd_t                  cmd,
  input  cdnu_pkg::cfg_t                     cfg,
  input  logic signed [cdnu_pkg::VAL_W-1:0]  in_demand,
  input  logic signed [cdnu_pkg::VAL_W-1:0]  in_renewable,
  input  logic signed [cdnu_pkg::VAL_W-1:0]  in_neighbor_price,
  input  logic signed [cdnu_pkg::VAL_W-1:0]  in_neighbor_mismatch_est,
  output cdnu_pkg::dp_status_t               status,
  output logic [cdnu_pkg::ITER_W-1:0]        out_iteration,
  output logic signed [cdnu_pkg::VAL_W-1:0]  out_price,
  output logic signed [cdnu_pkg::VAL_W-1:0]  out_mismatch_est,
  output logic signed [cdnu_pkg::VAL_W-1:0]  out_power,
  output logic                               out_done_res
);

  localparam int VW = cdnu_pkg::VAL_W;
  localparam int AW = cdnu_pkg::ACC_W;
  localparam int TW = cdnu_pkg::TERM_W;

  logic signed [VW-1:0] price_r, mism_r, est_r, power_r;
  logic signed [VW-1:0] snp_r, snm_r, demand_r, renew_r;
  logic signed [VW-1:0] np_r, pw_r, nm_r;
  logic [cdnu_pkg::ITER_W-1:0] round_r;
  logic                        boost_r;
  logic signed [AW-1:0]        acc_r;
  logic signed [cdnu_pkg::PROD_W-1:0] lo_r, hi_r;
  logic                        neg_r;
  logic [cdnu_pkg::REM_W-1:0]  rem_r;
  logic [cdnu_pkg::QUO_W-1:0]  dq_r;

  logic [cdnu_pkg::ITER_W-1:0] oit_r;
  logic signed [VW-1:0]        opr_r, oest_r, opw_r;
  logic                        odone_r;

  logic signed [VW-1:0]                mul_v;
  logic [cdnu_pkg::WEIGHT_W-1:0]       mul_w;
  logic signed [cdnu_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cdnu_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cdnu_pkg::PROD_W-1:0]  prod;
  logic signed [TW-1:0]                term_sum;
  logic signed [AW-1:0]                gain_term;
  logic signed [VW-1:0]                np_sat;
  logic [VW-1:0]                       np_mag;
  logic [cdnu_pkg::REM_W-1:0]          div_t;
  logic                                div_bit;
  logic signed [AW-1:0]                quot;
  logic signed [VW-1:0]                pw_sat;
  logic signed [VW-1:0]                pw_clamped;
  logic signed [VW-1:0]                ne;

  always_comb begin
    case (cmd.term)
      cdnu_pkg::TERM_OWN_PRICE:    mul_v = price_r;
      cdnu_pkg::TERM_NBR_PRICE:    mul_v = snp_r;
      cdnu_pkg::TERM_OWN_MISMATCH: mul_v = est_r;
      default:                     mul_v = snm_r;
    endcase
    mul_w = cmd.term[0] ? cfg.neighbor_weight : cfg.local_weight;
  end

  // A 48-bit value times a weight is built from a low and a high partial product.
  assign mul_a = (cmd.op == cdnu_pkg::OP_MUL_HI) ?
                 {mul_v[VW-1], mul_v[VW-1:cdnu_pkg::LO_W]} :
                 {1'b0, mul_v[cdnu_pkg::LO_W-1:0]};
  assign mul_b = {1'b0, mul_w};
  assign prod  = mul_a * mul_b;

  assign term_sum = (TW'(hi_r) <<< cdnu_pkg::LO_W) + TW'(lo_r)
                  + TW'(1 << (cdnu_pkg::WFRAC_W - 1));

  assign gain_term = boost_r ? AW'(est_r) * AW'(cdnu_pkg::BOOST_GAIN) : AW'(est_r);

  assign np_sat = cdnu_pkg::sat48(acc_r);
  assign np_mag = np_sat[VW-1] ? VW'(-np_sat) : VW'(np_sat);

  // One restoring division step: quotient bits shift in as dividend bits shift out.
  assign div_t   = {rem_r[cdnu_pkg::REM_W-2:0], dq_r[cdnu_pkg::QUO_W-1]};
  assign div_bit = div_t >= cdnu_pkg::REM_W'(cfg.unit_cost);

  assign quot   = neg_r ? -AW'(dq_r) : AW'(dq_r);
  assign pw_sat = cdnu_pkg::sat48(AW'(cfg.scheduled_power) + quot);

  always_comb begin
    if (pw_sat > cfg.power_max) begin
      pw_clamped = cfg.power_max;
    end else if (pw_sat < cfg.power_min) begin
      pw_clamped = cfg.power_min;
    end else begin
      pw_clamped = pw_sat;
    end
  end

  assign ne = cdnu_pkg::sat48(acc_r - AW'(mism_r) + AW'(nm_r));

  always_ff @(posedge clk) begin
    case (cmd.op)
      cdnu_pkg::OP_START: begin
        demand_r <= in_demand;
        renew_r  <= in_renewable;
        mism_r   <= cdnu_pkg::sat48(AW'(in_demand) - AW'(in_renewable));
        est_r    <= cdnu_pkg::sat48(AW'(in_demand) - AW'(in_renewable));
        price_r  <= '0;
        power_r  <= '0;
        snp_r    <= '0;
        snm_r    <= '0;
        acc_r    <= '0;
      end
      cdnu_pkg::OP_ACC: begin
        snp_r <= cdnu_pkg::sat48(AW'(snp_r) + AW'(in_neighbor_price));
        snm_r <= cdnu_pkg::sat48(AW'(snm_r) + AW'(in_neighbor_mismatch_est));
      end
      cdnu_pkg::OP_MUL_LO:   lo_r <= prod;
      cdnu_pkg::OP_MUL_HI:   hi_r <= prod;
      cdnu_pkg::OP_ADD_TERM: acc_r <= acc_r + AW'(term_sum >>> cdnu_pkg::WFRAC_W);
      cdnu_pkg::OP_ADD_GAIN: acc_r <= acc_r + gain_term;
      cdnu_pkg::OP_SAT_PRICE: begin
        np_r  <= np_sat;
        neg_r <= np_sat[VW-1];
        dq_r  <= {np_mag, cdnu_pkg::QSHIFT'(0)};
        rem_r <= '0;
        acc_r <= '0;
      end
      cdnu_pkg::OP_DIV_STEP: begin
        rem_r <= div_bit ? div_t - cdnu_pkg::REM_W'(cfg.unit_cost) : div_t;
        dq_r  <= {dq_r[cdnu_pkg::QUO_W-2:0], div_bit};
      end
      cdnu_pkg::OP_POWER: pw_r <= pw_clamped;
      cdnu_pkg::OP_MISMATCH:
        nm_r <= cdnu_pkg::sat48(AW'(demand_r) - AW'(pw_r) - AW'(renew_r));
      cdnu_pkg::OP_FINAL: begin
        price_r <= np_r;
        power_r <= pw_r;
        mism_r  <= nm_r;
        est_r   <= ne;
        snp_r   <= '0;
        snm_r   <= '0;
        acc_r   <= '0;
      end
      cdnu_pkg::OP_EMIT: begin
        oit_r   <= round_r;
        opr_r   <= price_r;
        oest_r  <= est_r;
        opw_r   <= power_r;
        odone_r <= round_r >= cfg.max_iterations;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r <= cdnu_pkg::ITER_W'(1);
      boost_r <= 1'b0;
    end else if (cmd.op == cdnu_pkg::OP_START) begin
      round_r <= cdnu_pkg::ITER_W'(1);
    end else if (cmd.op == cdnu_pkg::OP_FINAL) begin
      round_r <= round_r + cdnu_pkg::ITER_W'(1);
      // Once boosted, the gain stays high until reset.
      if (round_r >= cdnu_pkg::ITER_W'(cdnu_pkg::BOOST_ROUND) &&
          (ne >= cdnu_pkg::BOOST_THRESH || ne <= -cdnu_pkg::BOOST_THRESH)) begin
        boost_r <= 1'b1;
      end
    end
  end

  assign status.round_ge_max = round_r >= cfg.max_iterations;
  assign out_iteration       = oit_r;
  assign out_price           = opr_r;
  assign out_mismatch_est    = oest_r;
  assign out_power           = opw_r;
  assign out_done_res        = odone_r;

endmodule

// File: hw/rtl/consensus_dispatch_node_update_core.sv
`timescale 1ns / 1ps

// Consensus economic dispatch node. The in_ch channel carries start transactions
// (mode 0, local demand and renewable power) and neighbor transactions (mode 1,
// a neighbor's price and mismatch estimate). The out_ch channel carries the
// node's message: iteration, price, mismatch estimate, power and a done flag.
// Configuration registers are written through cfg_we, cfg_index and cfg_data,
// which the user must do only while the node is idle; the block does not check.
// A start transaction's message is registered as the node leaves its emit state,
// and the next transaction can be taken as that message becomes valid. Neighbor
// transactions are taken one per cycle until the configured count is reached;
// the last one starts an update, in which a 63-step bit-serial divider forms
// price over twice the cost. Weighted products use one 25x18 multiplier in two
// partial products each. No input is taken during an update.
// The result sits in an output register; while out_ch is stalled, the node
// still accepts transactions and only waits when the next message is ready.
// Reset is synchronous: configuration returns to its defaults, the round
// counter to 1, the gain to one and the node waits for a start transaction.
module consensus_dispatch_node_update_core #(
  parameter int MAX_NEIGHBORS = cdnu_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cdnu_in_if.sink                         in_ch,
  cdnu_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [cdnu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdnu_pkg::VAL_W-1:0]      cfg_data
);

  cdnu_pkg::cfg_t       cfg;
  cdnu_pkg::dp_cmd_t    cmd;
  cdnu_pkg::dp_status_t status;

  cdnu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cdnu_ctrl #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_mode        (in_ch.mode),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .neighbor_count (cfg.neighbor_count),
    .status         (status),
    .cmd            (cmd)
  );

  cdnu_datapath u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .cfg                      (cfg),
    .in_demand                (in_ch.demand),
    .in_renewable             (in_ch.renewable),
    .in_neighbor_price        (in_ch.neighbor_price),
    .in_neighbor_mismatch_est (in_ch.neighbor_mismatch_est),
    .status                   (status),
    .out_iteration            (out_ch.iteration),
    .out_price                (out_ch.price),
    .out_mismatch_est         (out_ch.mismatch_est),
    .out_power                (out_ch.power),
    .out_done_res             (out_ch.done_res)
  );

endmodule
